FILE: sv/lzt_pkg.sv
package lzt_pkg;

	localparam int PTR_BITS        = 16;
	localparam int DEF_BLOCK_BYTES = 4096;
	localparam int BB_BITS         = 13;
	localparam logic [3:0] LW_RESET = 4'd4;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_TOKEN  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [15:0]        pointer_word;
		logic [7:0]         literal;
		logic               token_last;
		logic               no_token;
		logic [BB_BITS-1:0] block_bytes;
		logic               overflow;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic append;
		logic clear;
		logic token_none;
		logic init;
		logic inc_len;
		logic end_off;
		logic sel_lit;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pos_done;
		logic off_ok;
		logic len_ok;
		logic eq;
		logic stop;
	} stat_t;

endpackage

FILE: sv/lzt_ram.sv
module lzt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one entry, read two, registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: sv/lzt_ctrl.sv
module lzt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    func,
	input  lzt_pkg::stat_t stat,
	output lzt_pkg::cmd_t  cmd,
	output logic          busy
);
	import lzt_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_OFFCHK = 3'd1;
	localparam logic [2:0] ST_ISSUE  = 3'd2;
	localparam logic [2:0] ST_CMP    = 3'd3;
	localparam logic [2:0] ST_ENDOFF = 3'd4;
	localparam logic [2:0] ST_LIT    = 3'd5;
	localparam logic [2:0] ST_LITW   = 3'd6;

	logic [2:0] state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	// sequence requests and the search: offsets outer, match bytes inner
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					priority case (func)
						FUNC_APPEND: cmd.append = 1'b1;
						FUNC_CLEAR:  cmd.clear  = 1'b1;
						FUNC_TOKEN: begin
							if (stat.pos_done) begin
								cmd.token_none = 1'b1;
							end else begin
								cmd.init = 1'b1;
								state_d  = ST_OFFCHK;
							end
						end
						default: ;
					endcase
				end
			end
			ST_OFFCHK: state_d = stat.off_ok ? ST_ISSUE : ST_LIT;
			ST_ISSUE:  state_d = stat.len_ok ? ST_CMP : ST_ENDOFF;
			ST_CMP: begin
				if (stat.eq) begin
					cmd.inc_len = 1'b1;
					state_d     = ST_ISSUE;
				end else begin
					state_d = ST_ENDOFF;
				end
			end
			ST_ENDOFF: begin
				cmd.end_off = 1'b1;
				state_d     = stat.stop ? ST_LIT : ST_OFFCHK;
			end
			ST_LIT: begin
				cmd.sel_lit = 1'b1;
				state_d     = ST_LITW;
			end
			ST_LITW: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a byte compare only follows an issued read
	a_cmp_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> $past(state_q) == ST_ISSUE)
		else $error("compare without read");
	// a token result is finished right after the literal read
	a_litw_after_lit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LITW |-> $past(state_q) == ST_LIT)
		else $error("literal not read");
	// commands only when idle for loads and clears
	a_append_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.append || cmd.clear) |-> !busy)
		else $error("load while busy");

endmodule

FILE: sv/lzt_datapath.sv
module lzt_datapath #(
	parameter int BLOCK_BYTES = lzt_pkg::DEF_BLOCK_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata,
	input  lzt_pkg::cmd_t  cmd,
	output lzt_pkg::stat_t stat,
	output lzt_pkg::res_t  result,
	output logic           strobe
);
	import lzt_pkg::*;

	localparam int AW = $clog2(BLOCK_BYTES);
	localparam int CW = $clog2(BLOCK_BYTES + 1);
	localparam int NW = (CW > PTR_BITS) ? CW : PTR_BITS + 1;

	logic [3:0]    lw_q;
	logic [CW-1:0] count_q, pos_q;
	logic          ovf_q;
	logic [NW-1:0] off_q, len_q, boff_q, blen_q, remain_q;
	res_t          res_q;
	logic          strobe_q;

	logic [3:0]    w;
	logic [NW-1:0] window, maxlen, pos_n, lit_addr;
	logic [7:0]    rd_a, rd_b;
	logic [AW-1:0] addr_a, addr_b;
	logic          full, wr_ok;
	logic [15:0]   off_sh, len_fld, word;
	logic [NW-1:0] newpos;

	assign w      = (lw_q == 4'd0) ? 4'd1 : lw_q;
	assign window = NW'(1) << (5'(PTR_BITS) - {1'b0, w});
	assign maxlen = NW'(1) << w;
	assign pos_n  = NW'(pos_q);
	assign wr_ok  = count_q < CW'(BLOCK_BYTES);

	// status toward the controller
	assign stat.pos_done = pos_q >= count_q;
	assign stat.off_ok   = (off_q < window) && (off_q <= pos_n);
	assign stat.len_ok   = (len_q < maxlen) && (len_q < remain_q);
	assign stat.eq       = rd_a == rd_b;
	assign stat.stop     = (len_q > blen_q) && (len_q == maxlen);

	// match that reaches the last byte gives its last byte as literal
	assign full     = (blen_q != '0) && (blen_q == remain_q);
	assign lit_addr = pos_n + blen_q - (full ? NW'(1) : NW'(0));
	assign addr_a   = cmd.sel_lit ? lit_addr[AW-1:0] : AW'(pos_n + len_q);
	assign addr_b   = AW'(pos_n - off_q + len_q);

	lzt_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_ram (
		.clk     (clk),
		.we      (cmd.append && wr_ok),
		.waddr   (count_q[AW-1:0]),
		.wdata   (data_byte),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// build the token word
	always_comb begin
		off_sh = boff_q[15:0] << w;
		if (full) begin
			len_fld = 16'(blen_q - NW'(2));
			word    = (blen_q == NW'(1)) ? 16'd0 : (off_sh | len_fld);
			newpos  = NW'(count_q);
		end else begin
			len_fld = (blen_q != '0) ? 16'(blen_q - NW'(1)) : 16'd0;
			word    = off_sh | len_fld;
			newpos  = pos_n + blen_q + NW'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q     <= LW_RESET;
			count_q  <= '0;
			pos_q    <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.token_none || cmd.finish;
			if (cfg_we) begin
				lw_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				count_q <= '0;
				pos_q   <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.append) begin
				if (wr_ok) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				pos_q <= CW'(newpos);
			end
		end
	end

	// search counters and result
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			off_q    <= NW'(1);
			len_q    <= '0;
			boff_q   <= '0;
			blen_q   <= '0;
			remain_q <= NW'(count_q) - pos_n;
		end
		if (cmd.inc_len) begin
			len_q <= len_q + NW'(1);
		end
		if (cmd.end_off) begin
			if (len_q > blen_q) begin
				blen_q <= len_q;
				boff_q <= off_q;
			end
			off_q <= off_q + NW'(1);
			len_q <= '0;
		end
		if (cmd.token_none) begin
			res_q.pointer_word <= '0;
			res_q.literal      <= '0;
			res_q.token_last   <= 1'b0;
			res_q.no_token     <= 1'b1;
			res_q.block_bytes  <= BB_BITS'(count_q);
			res_q.overflow     <= ovf_q;
		end
		if (cmd.finish) begin
			res_q.pointer_word <= word;
			res_q.literal      <= rd_a;
			res_q.token_last   <= newpos >= NW'(count_q);
			res_q.no_token     <= 1'b0;
			res_q.block_bytes  <= BB_BITS'(count_q);
			res_q.overflow     <= ovf_q;
		end
	end

	assign result = res_q;
	assign strobe = strobe_q;

endmodule

FILE: sv/lz77_token_compressor.sv
// LZ77 token compressor. Bytes are appended one per cycle while busy is low
// (func append), a block is restarted with func clear, and func token
// starts a search that ends in one result beat on result, marked by strobe
// for one cycle; the receiver cannot stall it, so it must take every beat.
// Load and clear leave busy low. Each byte compare of a token search is a
// read and then a compare on the two read ports of the text RAM, and the
// offset loop runs up to 2^(16-length_width)-1 offsets or until a match of
// full length is found. A token request on an exhausted block answers in
// the next cycle with no_token. The user must see that length_width is
// written through cfg_we/cfg_wdata only while busy is low; the block
// itself does not enforce it.
module lz77_token_compressor #(
	parameter int BLOCK_BYTES = lzt_pkg::DEF_BLOCK_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lzt_pkg::req_t req,
	output lzt_pkg::res_t result,
	output logic          strobe,
	input  logic          cfg_we,
	input  logic [3:0]    cfg_wdata
);
	import lzt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lzt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lzt_datapath #(.BLOCK_BYTES(BLOCK_BYTES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (req.data_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result),
		.strobe    (strobe)
	);

	// results only land while the block is idle again
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result while busy");
	// no-token beats carry an empty token
	a_no_token_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.no_token |->
		result.pointer_word == 16'd0 && result.literal == 8'd0 && !result.token_last)
		else $error("no-token beat not empty");
	// a load or clear beat causes no result
	a_no_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.func != FUNC_TOKEN |=> !strobe)
		else $error("result after load");

endmodule

FILE: bench/lz77_token_compressor_tb.sv
`timescale 1ns / 100ps

module lz77_token_compressor_tb;
	import lzt_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int STORE_DEPTH = DEF_BLOCK_BYTES;
	localparam int IDLE_LIMIT  = 400000;

	// Track the block contents and predict each token the block should emit
	class token_scoreboard;
		byte unsigned text[STORE_DEPTH];
		int           fill;
		int           coded;
		bit           dropped;
		logic [3:0]   width_reg;
		res_t         tokens_due[$];
		int           fails;
		int           checked;

		function new();
			fill = 0;
			coded = 0;
			dropped = 0;
			width_reg = LW_RESET;
			fails = 0;
			checked = 0;
		endfunction

		// Apply one accepted request beat; queue the token it causes
		function void note_request(req_t r);
			res_t e;
			int   w, window, maxlen, remain, off, len, best_off, best_len, nxt;
			bit   full;
			e = '0;
			best_off = 0;
			best_len = 0;
			full = 0;
			case (r.func)
				FUNC_APPEND: begin
					if (fill < STORE_DEPTH) begin
						text[fill] = r.data_byte;
						fill++;
					end else begin
						dropped = 1;
					end
				end
				FUNC_CLEAR: begin
					fill = 0;
					coded = 0;
					dropped = 0;
				end
				FUNC_TOKEN: begin
					e.block_bytes = fill[BB_BITS-1:0];
					e.overflow = dropped;
					if (coded >= fill) begin
						e.no_token = 1'b1;
					end else begin
						w = (width_reg == 0) ? 1 : width_reg;
						window = 1 << (PTR_BITS - w);
						maxlen = 1 << w;
						remain = fill - coded;
						// scan offsets nearest first; stop on a full-length match
						for (off = 1; off < window && off <= coded && !full; off++) begin
							len = 0;
							while (len < maxlen && len < remain &&
								text[coded + len] == text[coded - off + len])
								len++;
							if (len > best_len) begin
								best_off = off;
								best_len = len;
								full = (len == maxlen);
							end
						end
						if (best_len > 0 && best_len == remain) begin
							// match runs to the final byte: give that byte back as literal
							e.pointer_word = (best_len == 1) ? 16'd0 :
								16'((best_off << w) | (best_len - 2));
							e.literal = text[fill - 1];
							nxt = fill;
						end else begin
							e.pointer_word = 16'((best_off << w) |
								(best_len > 0 ? best_len - 1 : 0));
							e.literal = text[coded + best_len];
							nxt = coded + best_len + 1;
						end
						coded = nxt;
						e.token_last = (nxt >= fill);
					end
					tokens_due.push_back(e);
				end
				default: ;
			endcase
		endfunction

		function void field_chk(string nm, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, exp_v, act_v);
				fails++;
			end
		endfunction

		// Compare one result beat against the oldest pending token
		function void check_token(res_t got);
			res_t e;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				fails++;
				return;
			end
			e = tokens_due.pop_front();
			checked++;
			field_chk("pointer_word", e.pointer_word, got.pointer_word);
			field_chk("literal", e.literal, got.literal);
			field_chk("token_last", e.token_last, got.token_last);
			field_chk("no_token", e.no_token, got.no_token);
			field_chk("block_bytes", e.block_bytes, got.block_bytes);
			field_chk("overflow", e.overflow, got.overflow);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	req_t       req;
	res_t       result;
	logic       strobe;
	logic       cfg_we;
	logic [3:0] cfg_wdata;

	token_scoreboard tok;
	int              idle_cycles;
	int              widths_seen;

	lz77_token_compressor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.result    (result),
		.strobe    (strobe),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Take every result beat; check it
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			tok.check_token(result);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
			$display("lz77_token_compressor_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2, 3: return 8'h41 + 8'($urandom_range(0, 2));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Drive one request beat and hold it until accepted; then idle gap cycles
	task automatic send(logic [1:0] f, logic [7:0] d, int gap);
		req_t r;
		r.func = f;
		r.data_byte = d;
		start <= 1'b1;
		req <= r;
		do begin
			@(posedge clk);
		end while (busy);
		tok.note_request(r);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until the block has drained; let it settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tok.tokens_due.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_width(logic [3:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tok.width_reg = v;
		widths_seen |= (1 << v);
	endtask

	task automatic append_text(string s);
		foreach (s[i]) send(FUNC_APPEND, s[i], pick_gap());
	endtask

	initial begin
		int n, k, phase_items;
		tok = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_cycles = 0;
		widths_seen = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty block, ignored code, then repeats and a length-one final match
		send(FUNC_TOKEN, 8'h00, 0);
		send(FUNC_UNUSED, 8'hFF, 1);
		append_text("ABABAB");
		repeat (4) send(FUNC_TOKEN, 8'h00, pick_gap());
		send(FUNC_CLEAR, 8'h00, 0);
		append_text("AA");
		repeat (3) send(FUNC_TOKEN, 8'h00, 0);
		set_width(4'd0);
		send(FUNC_CLEAR, 8'h00, 0);
		append_text("xyzxyz");
		repeat (3) send(FUNC_TOKEN, 8'h00, 0);
		set_width(4'd15);
		send(FUNC_APPEND, 8'hFF, 0);
		send(FUNC_APPEND, 8'h00, 0);
		repeat (2) send(FUNC_TOKEN, 8'h00, 0);
		drain();

		// random blocks: fill, code, sometimes grow and code again
		phase_items = 0;
		while (phase_items < 548) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
					0: set_width(4'd1);
					1: set_width(4'd15);
					default: set_width(4'($urandom_range(0, 15)));
				endcase
			end
			send(FUNC_CLEAR, 8'h00, pick_gap());
			phase_items++;
			n = $urandom_range(0, 9) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 24);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 15) == 0)
					send(FUNC_UNUSED, 8'($urandom_range(0, 255)), pick_gap());
				else if ($urandom_range(0, 9) == 0)
					send(FUNC_TOKEN, 8'($urandom_range(0, 255)), pick_gap());
				else
					send(FUNC_APPEND, pick_byte(), pick_gap());
				phase_items++;
			end
			n = $urandom_range(2, 20);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 7) == 0)
					send(FUNC_APPEND, pick_byte(), pick_gap());
				else
					send(FUNC_TOKEN, 8'($urandom_range(0, 255)), pick_gap());
				phase_items++;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d token beats over directed and random blocks,",
			tok.checked);
		$display("and length widths mask 0x%04h.", widths_seen);
		if (tok.fails == 0 && tok.tokens_due.size() == 0) begin
			$display("lz77_token_compressor_tb: clean");
		end else begin
			$display("%0t: %0d mismatches, %0d tokens never came", $time, tok.fails,
				tok.tokens_due.size());
			$display("lz77_token_compressor_tb: errors");
		end
		$finish;
	end

endmodule
